>>> rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C register access master: beat
// structs of both channels, the queue entry, command classes and bus phases.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS    = 2'd0;
  localparam logic [1:0] CFG_PHASE_TICKS       = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT_TICKS = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers
  localparam logic [6:0]  DEV_ADDR_RST    = 7'd0;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd6;
  localparam logic [15:0] ACK_TMO_RST     = 16'd1000;
  localparam logic [15:0] PHASE_TICKS_MIN = 16'd2;

  // Opcode field values
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Input beat
  typedef struct packed {
    logic       command_valid;
    logic       opcode;
    logic [7:0] register_index;
    logic [7:0] write_value;
    logic       sda_sample;
  } i2cm_in_t;

  // Result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       status;
  } i2cm_out_t;

  // Class of one tick as seen by the front end
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_WR   = 2'd1,
    KIND_RD   = 2'd2
  } i2cm_kind_e;

  // Queue entry between front end and engine
  typedef struct packed {
    i2cm_kind_e kind;
    logic [7:0] reg_idx;
    logic [7:0] wr_val;
    logic       sda;
  } i2cm_entry_t;

  // Bus sequence phases, one-hot
  typedef enum logic [21:0] {
    PH_IDLE  = 22'd1 << 0,
    PH_ST1   = 22'd1 << 1,
    PH_ST2   = 22'd1 << 2,
    PH_ST3   = 22'd1 << 3,
    PH_WPRE  = 22'd1 << 4,
    PH_WLO   = 22'd1 << 5,
    PH_WHI   = 22'd1 << 6,
    PH_ALO   = 22'd1 << 7,
    PH_AHI   = 22'd1 << 8,
    PH_AWAIT = 22'd1 << 9,
    PH_APOST = 22'd1 << 10,
    PH_RPRE  = 22'd1 << 11,
    PH_RLO   = 22'd1 << 12,
    PH_RH1   = 22'd1 << 13,
    PH_RH2   = 22'd1 << 14,
    PH_NLO   = 22'd1 << 15,
    PH_NHI   = 22'd1 << 16,
    PH_NL2   = 22'd1 << 17,
    PH_NL3   = 22'd1 << 18,
    PH_SP1   = 22'd1 << 19,
    PH_SP2   = 22'd1 << 20,
    PH_SP3   = 22'd1 << 21
  } i2cm_phase_e;

endpackage

>>> rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Front end: takes input beats and classifies each tick as a plain tick,
// a register write command or a register read command.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  i2cm_pkg::i2cm_in_t    in_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output i2cm_pkg::i2cm_entry_t entry_o,
  output logic                  entry_valid_o,
  input  logic                  entry_ready_i
);
  import i2cm_pkg::*;

  i2cm_kind_e kind;

  // Classify the tick
  always_comb begin
    if (!in_data_i.command_valid) begin
      kind = KIND_TICK;
    end else if (in_data_i.opcode == OP_READ) begin
      kind = KIND_RD;
    end else begin
      kind = KIND_WR;
    end
  end

  // Pack the queue entry
  assign entry_o.kind    = kind;
  assign entry_o.reg_idx = in_data_i.register_index;
  assign entry_o.wr_val  = in_data_i.write_value;
  assign entry_o.sda     = in_data_i.sda_sample;

  assign entry_valid_o = in_valid_i;
  assign in_ready_o    = entry_ready_i;

endmodule

>>> rtl/i2cm_fifo.sv
// ----------------------------------------------------------------------------
// i2cm_fifo
// Two-entry queue of classified ticks between the front end and the engine.
// ----------------------------------------------------------------------------
module i2cm_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cm_pkg::i2cm_entry_t wr_data_i,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  output i2cm_pkg::i2cm_entry_t rd_data_o,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i
);
  import i2cm_pkg::*;

  i2cm_entry_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> rtl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Back end: steps the bus sequencer once per queued tick, holds the
// configuration registers and registers the result beat.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [i2cm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [i2cm_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  i2cm_pkg::i2cm_entry_t            entry_i,
  input  logic                             entry_valid_i,
  output logic                             entry_ready_o,
  output i2cm_pkg::i2cm_out_t              out_data_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i
);
  import i2cm_pkg::*;

  // Configuration
  logic [6:0]  dev_addr_q;
  logic [15:0] phase_ticks_q;
  logic [15:0] ack_tmo_q;

  // Sequencer state
  i2cm_phase_e phase_q, phase_d;
  logic [2:0]  byte_stage_q, byte_stage_d;
  logic [2:0]  bit_cnt_q, bit_cnt_d;
  logic [15:0] delay_q, delay_d;
  logic [15:0] ackw_q, ackw_d;
  logic [7:0]  shift_q, shift_d;
  logic        is_read_q, is_read_d;
  logic [7:0]  reg_idx_q, reg_idx_d;
  logic [7:0]  wr_val_q, wr_val_d;
  logic [7:0]  read_q, read_d;
  logic        err_q, err_d;
  logic        sda_last_q, sda_last_d;

  // Result register
  logic        out_valid_q;
  i2cm_out_t   out_q, out_d;

  // Step helpers
  logic [15:0] dur_full, dur_half, dur;
  logic        scl, lvl, drv, done, bit_val;
  logic [2:0]  stage_inc;
  logic        step;

  assign step          = entry_valid_i && (!out_valid_q || out_ready_i);
  assign entry_ready_o = step;
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;

  assign dur_full = (phase_ticks_q < PHASE_TICKS_MIN) ? PHASE_TICKS_MIN : phase_ticks_q;
  assign dur_half = dur_full >> 1;

  // Compute one tick of the bus sequence
  always_comb begin
    phase_d      = phase_q;
    byte_stage_d = byte_stage_q;
    bit_cnt_d    = bit_cnt_q;
    delay_d      = delay_q;
    ackw_d       = ackw_q;
    shift_d      = shift_q;
    is_read_d    = is_read_q;
    reg_idx_d    = reg_idx_q;
    wr_val_d     = wr_val_q;
    read_d       = read_q;
    err_d        = err_q;
    sda_last_d   = sda_last_q;
    scl          = 1'b1;
    drv          = 1'b1;
    lvl          = 1'b1;
    dur          = dur_full;
    done         = 1'b0;
    stage_inc    = byte_stage_q + 3'd1;
    bit_val      = shift_q[bit_cnt_q];

    // Latch a command when idle
    if (phase_q == PH_IDLE && entry_i.kind != KIND_TICK) begin
      is_read_d    = (entry_i.kind == KIND_RD);
      reg_idx_d    = entry_i.reg_idx;
      wr_val_d     = entry_i.wr_val;
      byte_stage_d = 3'd0;
      bit_cnt_d    = 3'd0;
      err_d        = 1'b0;
      delay_d      = 16'd0;
      phase_d      = PH_ST1;
    end
    stage_inc = byte_stage_d + 3'd1;

    // Drive the lines for the current phase
    case (phase_d)
      PH_ST2:   lvl = 1'b0;
      PH_ST3:   begin scl = 1'b0; lvl = 1'b0; end
      PH_WPRE:  begin scl = 1'b0; lvl = sda_last_q; end
      PH_WLO:   begin scl = 1'b0; lvl = bit_val; end
      PH_WHI:   lvl = bit_val;
      PH_ALO, PH_RPRE, PH_RLO: begin scl = 1'b0; drv = 1'b0; end
      PH_AHI, PH_APOST, PH_RH1, PH_RH2: begin drv = 1'b0; dur = dur_half; end
      PH_AWAIT: drv = 1'b0;
      PH_NLO, PH_NL2, PH_NL3: scl = 1'b0;
      PH_SP1:   begin scl = 1'b0; lvl = 1'b0; end
      PH_SP2:   lvl = 1'b0;
      default:  ;
    endcase
    if (!drv) begin
      lvl = 1'b0;
    end else begin
      sda_last_d = lvl;
    end

    // Wait for ACK or time out
    if (phase_d == PH_AWAIT) begin
      if (ackw_q >= ack_tmo_q) begin
        err_d   = 1'b1;
        delay_d = 16'd0;
        phase_d = PH_APOST;
      end else if (!entry_i.sda) begin
        delay_d = 16'd0;
        phase_d = PH_APOST;
      end else begin
        ackw_d = ackw_q + 16'd1;
      end
    end else if (phase_d != PH_IDLE) begin
      // Sample the read bit at the start of the second high half
      if (phase_d == PH_RH2 && delay_d == 16'd0) begin
        shift_d = {shift_q[6:0], entry_i.sda};
      end
      if ({1'b0, delay_d} + 17'd1 >= {1'b0, dur}) begin
        delay_d = 16'd0;
        // Advance to the next phase
        case (phase_d)
          PH_ST1:  phase_d = PH_ST2;
          PH_ST2:  phase_d = PH_ST3;
          PH_ST3: begin
            shift_d   = {dev_addr_q, (byte_stage_d >= 3'd2)};
            bit_cnt_d = 3'd7;
            phase_d   = PH_WPRE;
          end
          PH_WPRE: phase_d = PH_WLO;
          PH_WLO:  phase_d = PH_WHI;
          PH_WHI: begin
            if (bit_cnt_d == 3'd0) begin
              phase_d = PH_ALO;
            end else begin
              bit_cnt_d = bit_cnt_d - 3'd1;
              phase_d   = PH_WLO;
            end
          end
          PH_ALO:  phase_d = PH_AHI;
          PH_AHI: begin
            ackw_d  = 16'd0;
            phase_d = PH_AWAIT;
          end
          PH_APOST: begin
            if (err_d) begin
              phase_d = PH_SP1;
            end else begin
              byte_stage_d = stage_inc;
              if (stage_inc == 3'd1) begin
                shift_d   = reg_idx_d;
                bit_cnt_d = 3'd7;
                phase_d   = PH_WPRE;
              end else if (stage_inc == 3'd2) begin
                if (is_read_d) begin
                  phase_d = PH_ST1;
                end else begin
                  shift_d   = wr_val_d;
                  bit_cnt_d = 3'd7;
                  phase_d   = PH_WPRE;
                end
              end else if (stage_inc == 3'd3 && is_read_d) begin
                shift_d   = 8'd0;
                bit_cnt_d = 3'd7;
                phase_d   = PH_RPRE;
              end else begin
                phase_d = PH_SP1;
              end
            end
          end
          PH_RPRE: phase_d = PH_RLO;
          PH_RLO:  phase_d = PH_RH1;
          PH_RH1:  phase_d = PH_RH2;
          PH_RH2: begin
            if (bit_cnt_d == 3'd0) begin
              phase_d = PH_NLO;
            end else begin
              bit_cnt_d = bit_cnt_d - 3'd1;
              phase_d   = PH_RLO;
            end
          end
          PH_NLO:  phase_d = PH_NHI;
          PH_NHI:  phase_d = PH_NL2;
          PH_NL2:  phase_d = PH_NL3;
          PH_NL3: begin
            read_d  = shift_d;
            phase_d = PH_SP1;
          end
          PH_SP1:  phase_d = PH_SP2;
          PH_SP2:  phase_d = PH_SP3;
          default: begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        endcase
      end else begin
        delay_d = delay_d + 16'd1;
      end
    end

    // Assemble the result beat
    out_d.scl_level  = scl;
    out_d.sda_level  = lvl;
    out_d.sda_drive  = drv;
    out_d.busy_res   = (phase_q != PH_IDLE) || (entry_i.kind != KIND_TICK);
    out_d.done_res   = done;
    out_d.read_value = read_d;
    out_d.status     = done & err_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DEV_ADDR_RST;
      phase_ticks_q <= PHASE_TICKS_RST;
      ack_tmo_q     <= ACK_TMO_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEVICE_ADDRESS:    dev_addr_q    <= cfg_wdata_i[6:0];
        CFG_PHASE_TICKS:       phase_ticks_q <= cfg_wdata_i;
        CFG_ACK_TIMEOUT_TICKS: ack_tmo_q     <= cfg_wdata_i;
        default:               ;
      endcase
    end
  end

  // Sequencer state update, one step per consumed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      byte_stage_q <= 3'd0;
      bit_cnt_q    <= 3'd0;
      delay_q      <= 16'd0;
      ackw_q       <= 16'd0;
      shift_q      <= 8'd0;
      is_read_q    <= 1'b0;
      reg_idx_q    <= 8'd0;
      wr_val_q     <= 8'd0;
      read_q       <= 8'd0;
      err_q        <= 1'b0;
      sda_last_q   <= 1'b1;
    end else if (step) begin
      phase_q      <= phase_d;
      byte_stage_q <= byte_stage_d;
      bit_cnt_q    <= bit_cnt_d;
      delay_q      <= delay_d;
      ackw_q       <= ackw_d;
      shift_q      <= shift_d;
      is_read_q    <= is_read_d;
      reg_idx_q    <= reg_idx_d;
      wr_val_q     <= wr_val_d;
      read_q       <= read_d;
      err_q        <= err_d;
      sda_last_q   <= sda_last_d;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

endmodule

>>> rtl/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Each tick beat passes the two-entry queue; the engine registers its result.
// Throughput: one tick beat per cycle while the sink takes results. The engine
// steps once per queued tick; the queue and result register decouple stalls.
// Reset: asynchronous, active low; configuration returns to its defaults,
// the sequencer goes idle with both bus lines high and the queue empties.
// ----------------------------------------------------------------------------
module i2c_master_register_access (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [i2cm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  i2cm_pkg::i2cm_in_t            in_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output i2cm_pkg::i2cm_out_t           out_data_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i
);
  import i2cm_pkg::*;

  i2cm_entry_t front_entry, queue_entry;
  logic        front_valid, front_ready;
  logic        queue_valid, queue_ready;

  // Classify incoming ticks
  i2cm_front u_front (
    .in_data_i     (in_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .entry_o       (front_entry),
    .entry_valid_o (front_valid),
    .entry_ready_i (front_ready)
  );

  // Buffer classified ticks
  i2cm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (front_entry),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_data_o  (queue_entry),
    .rd_valid_o (queue_valid),
    .rd_ready_i (queue_ready)
  );

  // Run the bus sequence
  i2cm_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_i       (queue_entry),
    .entry_valid_i (queue_valid),
    .entry_ready_o (queue_ready),
    .out_data_o    (out_data_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: I2C register access master
// Sends one tick beat per bus timer tick: SDA samples, register writes and
// register reads. Each result beat is checked against a tick-accurate
// in-bench model of the bus sequencer. A short directed table runs first.
// Random sessions follow, each with its own address, phase length and ACK
// timeout. Both handshakes idle and stall at random, and the sink holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam int unsigned CLK_PERIOD       = 10;
  localparam int unsigned RESET_CYCLES     = 11;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES     = 20;
  localparam int unsigned MAX_REPORTS      = 200;
  localparam int unsigned RUN_LIMIT_NS     = 2_000_000;

  // Short bus timing for the directed table
  localparam logic [15:0] DIR_DEV_WORD = 16'h0050;
  localparam logic [15:0] DIR_PHASE    = 16'd2;
  localparam logic [15:0] DIR_TMO      = 16'd8;

  // Bus lines while idle, and on the first START tick of a transaction
  localparam i2cm_out_t IDLE_LINES = '{scl_level: 1'b1, sda_level: 1'b1, sda_drive: 1'b1,
                                       busy_res: 1'b0, done_res: 1'b0, read_value: 8'h00,
                                       status: 1'b0};
  localparam i2cm_out_t START_LINES = '{scl_level: 1'b1, sda_level: 1'b1, sda_drive: 1'b1,
                                        busy_res: 1'b1, done_res: 1'b0, read_value: 8'h00,
                                        status: 1'b0};

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_pattern_e;

  // One directed row: the beat is sent reps times, the command only once
  typedef struct {
    i2cm_in_t    beat;
    int unsigned reps;
    logic        typed;
    i2cm_out_t   want;
  } dir_row_t;

  typedef struct {
    logic [6:0]  dev;
    logic [15:0] phase;
    logic [15:0] tmo;
    int unsigned ticks;
    int unsigned sda_low_pct;
    logic        long_hold;
  } bus_setting_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  i2cm_in_t            in_data_i   = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  i2cm_out_t           out_data_o;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;

  i2c_master_register_access dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Directed table, run at a short phase and ACK timeout so each
  // transaction ends within its row of idle ticks
  dir_row_t plan [13] = '{
    '{'{1'b0, OP_WRITE, 8'h00, 8'h00, 1'b0}, 1,   1'b1, IDLE_LINES},
    '{'{1'b0, OP_READ,  8'hFF, 8'hFF, 1'b1}, 1,   1'b1, IDLE_LINES},
    '{'{1'b1, OP_WRITE, 8'hFF, 8'h00, 1'b0}, 1,   1'b1, START_LINES},
    '{'{1'b0, OP_WRITE, 8'h00, 8'h00, 1'b0}, 10,  1'b0, IDLE_LINES},
    // read command while the write is still on the bus: dropped
    '{'{1'b1, OP_READ,  8'h00, 8'hFF, 1'b0}, 1,   1'b0, IDLE_LINES},
    '{'{1'b0, OP_WRITE, 8'h00, 8'h00, 1'b0}, 150, 1'b0, IDLE_LINES},
    '{'{1'b0, OP_READ,  8'hAA, 8'h55, 1'b1}, 1,   1'b1, IDLE_LINES},
    '{'{1'b1, OP_READ,  8'h00, 8'hFF, 1'b0}, 1,   1'b1, START_LINES},
    '{'{1'b0, OP_READ,  8'h00, 8'h00, 1'b0}, 200, 1'b0, IDLE_LINES},
    '{'{1'b0, OP_WRITE, 8'h3C, 8'hC3, 1'b0}, 1,   1'b1, IDLE_LINES},
    // SDA never pulled low: the address ACK times out
    '{'{1'b1, OP_WRITE, 8'h5A, 8'hA5, 1'b1}, 1,   1'b1, START_LINES},
    '{'{1'b0, OP_WRITE, 8'h00, 8'h00, 1'b1}, 100, 1'b0, IDLE_LINES},
    '{'{1'b0, OP_READ,  8'h81, 8'h7E, 1'b0}, 1,   1'b1, IDLE_LINES}
  };

  // Random sessions: mostly short phases and tight timeouts keep transactions frequent
  bus_setting_t settings [7] = '{
    '{7'd127, 16'd2,     16'd1,     250, 70, 1'b0},
    '{7'd0,   16'd0,     16'd0,     140, 60, 1'b0},
    '{7'h55,  16'd1,     16'd65535, 180, 40, 1'b1},
    '{7'h2A,  16'd3,     16'd4,     210, 65, 1'b0},
    '{7'h13,  16'd65535, 16'd9,     40,  50, 1'b0},
    '{7'h6C,  16'd2,     16'd12,    250, 75, 1'b0},
    '{7'h31,  16'd6,     16'd1000,  110, 80, 1'b0}
  };

  // Bus model state and its copy of the registers
  logic [6:0]  m_dev_addr  = DEV_ADDR_RST;
  logic [15:0] m_phase     = PHASE_TICKS_RST;
  logic [15:0] m_ack_tmo   = ACK_TMO_RST;
  i2cm_phase_e p_phase     = PH_IDLE;
  logic [2:0]  p_stage     = '0;
  logic [3:0]  p_bit       = '0;
  logic [15:0] p_delay     = '0;
  logic [15:0] p_ackwait   = '0;
  logic [7:0]  p_shift     = '0;
  logic        p_cmd_read  = 1'b0;
  logic [7:0]  p_cmd_reg   = '0;
  logic [7:0]  p_cmd_val   = '0;
  logic [7:0]  p_read      = '0;
  logic        p_err       = 1'b0;
  logic        p_sda_last  = 1'b1;

  i2cm_out_t   pending_ticks_q [$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned pattern_left   = 0;
  rx_pattern_e rx_pattern     = RX_STEADY;
  logic [7:0]  sink_phase     = '0;

  // Load a byte to shift out MSB first
  function automatic void load_tx_byte(input logic [7:0] value);
    p_shift = value;
    p_bit   = 4'd7;
    p_phase = PH_WPRE;
  endfunction

  // Close a timed phase and pick the next; returns 1 when STOP has ended
  function automatic logic close_bus_phase();
    logic fin;
    fin = 1'b0;
    case (p_phase)
      PH_ST1:  p_phase = PH_ST2;
      PH_ST2:  p_phase = PH_ST3;
      PH_ST3:  load_tx_byte({m_dev_addr, p_stage >= 3'd2});
      PH_WPRE: p_phase = PH_WLO;
      PH_WLO:  p_phase = PH_WHI;
      PH_WHI: begin
        if (p_bit == 4'd0) begin
          p_phase = PH_ALO;
        end else begin
          p_bit   = p_bit - 4'd1;
          p_phase = PH_WLO;
        end
      end
      PH_ALO:  p_phase = PH_AHI;
      PH_AHI: begin
        p_ackwait = '0;
        p_phase   = PH_AWAIT;
      end
      PH_APOST: begin
        if (p_err) begin
          p_phase = PH_SP1;
        end else begin
          // advance to the next byte of the transaction
          p_stage = p_stage + 3'd1;
          if (p_stage == 3'd1) begin
            load_tx_byte(p_cmd_reg);
          end else if (p_stage == 3'd2) begin
            if (p_cmd_read) p_phase = PH_ST1;
            else load_tx_byte(p_cmd_val);
          end else if (p_stage == 3'd3 && p_cmd_read) begin
            p_shift = '0;
            p_bit   = 4'd7;
            p_phase = PH_RPRE;
          end else begin
            p_phase = PH_SP1;
          end
        end
      end
      PH_RPRE: p_phase = PH_RLO;
      PH_RLO:  p_phase = PH_RH1;
      PH_RH1:  p_phase = PH_RH2;
      PH_RH2: begin
        if (p_bit == 4'd0) begin
          p_phase = PH_NLO;
        end else begin
          p_bit   = p_bit - 4'd1;
          p_phase = PH_RLO;
        end
      end
      PH_NLO:  p_phase = PH_NHI;
      PH_NHI:  p_phase = PH_NL2;
      PH_NL2:  p_phase = PH_NL3;
      PH_NL3: begin
        p_read  = p_shift;
        p_phase = PH_SP1;
      end
      PH_SP1:  p_phase = PH_SP2;
      PH_SP2:  p_phase = PH_SP3;
      default: begin
        p_phase = PH_IDLE;
        fin     = 1'b1;
      end
    endcase
    return fin;
  endfunction

  // Step the bus model by one tick and return the line levels and status
  function automatic i2cm_out_t next_bus_levels(input i2cm_in_t t);
    int unsigned d;
    int unsigned dur;
    logic        scl;
    logic        drv;
    logic        lvl;
    logic        bit_now;
    logic        busy;
    logic        fin;
    i2cm_out_t   r;
    d       = (m_phase < PHASE_TICKS_MIN) ? PHASE_TICKS_MIN : m_phase;
    dur     = d;
    scl     = 1'b1;
    drv     = 1'b1;
    lvl     = 1'b1;
    fin     = 1'b0;
    bit_now = p_shift[p_bit[2:0]];

    // latch a command only when idle; its tick is already the first START tick
    if (p_phase == PH_IDLE && t.command_valid) begin
      p_cmd_read = (t.opcode == OP_READ);
      p_cmd_reg  = t.register_index;
      p_cmd_val  = t.write_value;
      p_stage    = '0;
      p_bit      = '0;
      p_err      = 1'b0;
      p_delay    = '0;
      p_phase    = PH_ST1;
    end

    case (p_phase)
      PH_ST2:                          lvl = 1'b0;
      PH_ST3, PH_SP1:                  begin scl = 1'b0; lvl = 1'b0; end
      PH_WPRE:                         begin scl = 1'b0; lvl = p_sda_last; end
      PH_WLO:                          begin scl = 1'b0; lvl = bit_now; end
      PH_WHI:                          lvl = bit_now;
      PH_ALO, PH_RPRE, PH_RLO:         begin scl = 1'b0; drv = 1'b0; end
      PH_AHI, PH_APOST, PH_RH1, PH_RH2: begin drv = 1'b0; dur = d >> 1; end
      PH_AWAIT:                        drv = 1'b0;
      PH_NLO, PH_NL2, PH_NL3:          scl = 1'b0;
      PH_SP2:                          lvl = 1'b0;
      default: ;
    endcase
    if (!drv) lvl = 1'b0;
    else p_sda_last = lvl;
    busy = (p_phase != PH_IDLE);

    if (p_phase == PH_AWAIT) begin
      if (p_ackwait >= m_ack_tmo) begin
        p_err   = 1'b1;
        p_delay = '0;
        p_phase = PH_APOST;
      end else if (!t.sda_sample) begin
        p_delay = '0;
        p_phase = PH_APOST;
      end else begin
        p_ackwait = p_ackwait + 16'd1;
      end
    end else if (p_phase != PH_IDLE) begin
      // sample SDA on the first tick of the second high half
      if (p_phase == PH_RH2 && p_delay == 16'd0) p_shift = {p_shift[6:0], t.sda_sample};
      if (32'(p_delay) + 1 >= dur) begin
        p_delay = '0;
        fin     = close_bus_phase();
      end else begin
        p_delay = p_delay + 16'd1;
      end
    end

    r.scl_level  = scl;
    r.sda_level  = lvl;
    r.sda_drive  = drv;
    r.busy_res   = busy;
    r.done_res   = fin;
    r.read_value = p_read;
    r.status     = fin & p_err;
    return r;
  endfunction

  // Offer one beat, hold it until accepted, then queue its expected result
  task automatic send_tick(input i2cm_in_t beat, input logic typed, input i2cm_out_t want);
    i2cm_out_t model_res;
    in_data_i  <= beat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    model_res = next_bus_levels(beat);
    pending_ticks_q.push_back(typed ? want : model_res);
  endtask

  // Insert a random gap between bursts; some bursts run long with no gap
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    burst_left--;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_ticks_q.size() != 0) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive edges
  task automatic apply_settings(input logic [15:0] dev_word, input logic [15:0] phase,
                                input logic [15:0] tmo);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DEVICE_ADDRESS;
    cfg_wdata_i <= dev_word;
    @(posedge clk_i);
    cfg_index_i <= CFG_PHASE_TICKS;
    cfg_wdata_i <= phase;
    @(posedge clk_i);
    cfg_index_i <= CFG_ACK_TIMEOUT_TICKS;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    m_dev_addr = dev_word[6:0];
    m_phase    = phase;
    m_ack_tmo  = tmo;
  endtask

  task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      if (mismatch_count < MAX_REPORTS)
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Sink: own stall patterns, plus a long hold-off on request
  always @(posedge clk_i) begin : result_sink
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        rx_pattern   = rx_pattern_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(32, 400);
      end
      pattern_left--;
      sink_phase++;
      case (rx_pattern)
        RX_STEADY: out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready_i <= (sink_phase[1:0] == 2'd0);
        default:   out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    i2cm_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_ticks_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) $error("result beat with no tick outstanding");
        mismatch_count++;
      end else begin
        want = pending_ticks_q.pop_front();
        report_field("scl_level",  8'(want.scl_level),  8'(out_data_o.scl_level));
        report_field("sda_level",  8'(want.sda_level),  8'(out_data_o.sda_level));
        report_field("sda_drive",  8'(want.sda_drive),  8'(out_data_o.sda_drive));
        report_field("busy_res",   8'(want.busy_res),   8'(out_data_o.busy_res));
        report_field("done_res",   8'(want.done_res),   8'(out_data_o.done_res));
        report_field("read_value", want.read_value,     out_data_o.read_value);
        report_field("status",     8'(want.status),     8'(out_data_o.status));
      end
    end
  end

  initial begin : stimulus
    i2cm_in_t    beat;
    logic [8:0]  addr_pad;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Shorten the bus timing, then walk the directed table
    apply_settings(DIR_DEV_WORD, DIR_PHASE, DIR_TMO);
    foreach (plan[r]) begin
      beat = plan[r].beat;
      for (int unsigned k = 0; k < plan[r].reps; k++) begin
        pace_sender();
        send_tick(beat, plan[r].typed && k == 0, plan[r].want);
        beat.command_valid = 1'b0;
      end
    end

    // Random sessions, reconfigured only once all results are back
    foreach (settings[s]) begin
      drain_results();
      addr_pad = 9'($urandom_range(0, 511));
      apply_settings({addr_pad, settings[s].dev}, settings[s].phase, settings[s].tmo);
      if (settings[s].long_hold) hold_requests++;
      repeat (settings[s].ticks) begin
        pace_sender();
        beat.command_valid  = ($urandom_range(0, 3) == 0);
        beat.opcode         = 1'($urandom_range(0, 1));
        beat.register_index = 8'($urandom_range(0, 255));
        beat.write_value    = 8'($urandom_range(0, 255));
        beat.sda_sample     = ($urandom_range(0, 99) >= settings[s].sda_low_pct);
        send_tick(beat, 1'b0, IDLE_LINES);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
